/* hw/rtl/mrwt_pkg.sv */
// Shared types and constants for the Miller-Rabin witness test block.
// No dependencies; used by mrwt_modmul and miller_rabin_witness_test.
package mrwt_pkg;

    localparam int NUM_BITS = 64;
    localparam int CNT_W    = $clog2(NUM_BITS);
    localparam int T_W      = $clog2(NUM_BITS);

    typedef logic [NUM_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        V_PRIME     = 2'd0,
        V_TRIVIAL   = 2'd1,
        V_COMPOSITE = 2'd2,
        V_PROBABLE  = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_RED,
        ST_PW_MUL,
        ST_PW_SQ,
        ST_SQ,
        ST_FINISH
    } state_t;

    // request to the modular multiplier: product x*y mod m, x < m
    typedef struct packed {
        logic  start;
        word_t x;
        word_t y;
        word_t m;
    } mul_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t prod;
    } mul_rsp_t;

endpackage

/* hw/rtl/miller_rabin_witness_test.sv */
// Miller-Rabin witness test top level: sequencer, result register, checks.
// Depends on mrwt_pkg and mrwt_modmul.
//
// One transfer in carries a candidate n and a base a; one transfer out carries
// the verdict (0 n is two, 1 trivially not prime, 2 witnessed composite,
// 3 probably prime). Only the low NUM_BITS bits of each field are used, and
// the base is reduced modulo n first. An odd candidate takes one reduction
// of the base, one or two modular products per bit of the odd part u of n-1,
// and up to t squarings, where n-1 = 2^t*u, after the factor 2^t has been
// split off. For 64 bits this is at most about 128 products, all on the
// single bit-serial multiplier. One item is worked on at a time; a new item
// is taken while the previous verdict still waits in the output register.
module miller_rabin_witness_test (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] candidate, [127:64] base
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata    // [1:0] verdict, [7:2] zero
);

    mrwt_pkg::state_t   state_reg, state_next;
    mrwt_pkg::word_t    n_reg, n_next;
    mrwt_pkg::word_t    a_reg, a_next;       // base, later the running square
    mrwt_pkg::word_t    acc_reg, acc_next;   // power accumulator, later cur
    mrwt_pkg::word_t    e_reg, e_next;       // exponent u, shifted right
    logic [mrwt_pkg::T_W-1:0] t_reg, t_next; // squarings left
    mrwt_pkg::verdict_t res_reg, res_next;
    logic               pend_reg, pend_next; // multiply in flight
    logic               out_vld_reg, out_vld_next;
    mrwt_pkg::verdict_t out_reg, out_next;

    mrwt_pkg::mul_req_t mreq;
    mrwt_pkg::mul_rsp_t mrsp;

    mrwt_pkg::word_t cand, base, nm1;
    logic            acc_is_one, sq_is_one;

    mrwt_modmul u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (mreq),
        .rsp    (mrsp)
    );

    assign cand       = s_tdata[mrwt_pkg::NUM_BITS-1:0];
    assign base       = s_tdata[64 + mrwt_pkg::NUM_BITS-1:64];
    assign nm1        = n_reg - 1'b1;
    assign acc_is_one = (acc_reg == mrwt_pkg::NUM_BITS'(1));
    assign sq_is_one  = (mrsp.prod == mrwt_pkg::NUM_BITS'(1));

    assign s_tready = (state_reg == mrwt_pkg::ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mrwt_pkg::ST_IDLE;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
        n_reg   <= n_next;
        a_reg   <= a_next;
        acc_reg <= acc_next;
        e_reg   <= e_next;
        t_reg   <= t_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        a_next       = a_reg;
        acc_next     = acc_reg;
        e_next       = e_reg;
        t_next       = t_reg;
        res_next     = res_reg;
        pend_next    = pend_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        mreq.start   = 1'b0;
        mreq.x       = acc_reg;
        mreq.y       = a_reg;
        mreq.m       = n_reg;

        if (m_tvalid && m_tready) begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            mrwt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_next   = cand;
                    a_next   = base;
                    e_next   = cand - 1'b1;
                    t_next   = '0;
                    acc_next = mrwt_pkg::NUM_BITS'(1);
                    if (cand == mrwt_pkg::NUM_BITS'(2)) begin
                        res_next   = mrwt_pkg::V_PRIME;
                        state_next = mrwt_pkg::ST_FINISH;
                    end else if (!cand[0] || cand == mrwt_pkg::NUM_BITS'(1)) begin
                        res_next   = mrwt_pkg::V_TRIVIAL;
                        state_next = mrwt_pkg::ST_FINISH;
                    end else begin
                        state_next = mrwt_pkg::ST_SPLIT;
                    end
                end
            end
            // strip factors of two from n-1
            mrwt_pkg::ST_SPLIT: begin
                if (e_reg[0]) begin
                    state_next = mrwt_pkg::ST_RED;
                end else begin
                    e_next = e_reg >> 1;
                    t_next = t_reg + 1'b1;
                end
            end
            // base mod n, as 1 * base mod n
            mrwt_pkg::ST_RED: begin
                mreq.x = mrwt_pkg::NUM_BITS'(1);
                mreq.y = a_reg;
                if (!pend_reg) begin
                    mreq.start = 1'b1;
                    pend_next  = 1'b1;
                end else if (mrsp.done) begin
                    pend_next  = 1'b0;
                    a_next     = mrsp.prod;
                    state_next = mrwt_pkg::ST_PW_MUL;
                end
            end
            mrwt_pkg::ST_PW_MUL: begin
                mreq.x = acc_reg;
                mreq.y = a_reg;
                if (!e_reg[0]) begin
                    state_next = mrwt_pkg::ST_PW_SQ;
                end else if (!pend_reg) begin
                    mreq.start = 1'b1;
                    pend_next  = 1'b1;
                end else if (mrsp.done) begin
                    pend_next  = 1'b0;
                    acc_next   = mrsp.prod;
                    state_next = mrwt_pkg::ST_PW_SQ;
                end
            end
            mrwt_pkg::ST_PW_SQ: begin
                mreq.x = a_reg;
                mreq.y = a_reg;
                if (!pend_reg) begin
                    mreq.start = 1'b1;
                    pend_next  = 1'b1;
                end else if (mrsp.done) begin
                    pend_next = 1'b0;
                    a_next    = mrsp.prod;
                    e_next    = e_reg >> 1;
                    if ((e_reg >> 1) == '0) begin
                        state_next = mrwt_pkg::ST_SQ;
                    end else begin
                        state_next = mrwt_pkg::ST_PW_MUL;
                    end
                end
            end
            // t squarings of cur, watching for a nontrivial root of one
            mrwt_pkg::ST_SQ: begin
                mreq.x = acc_reg;
                mreq.y = acc_reg;
                if (!pend_reg) begin
                    mreq.start = 1'b1;
                    pend_next  = 1'b1;
                end else if (mrsp.done) begin
                    pend_next = 1'b0;
                    acc_next  = mrsp.prod;
                    t_next    = t_reg - 1'b1;
                    if (sq_is_one && !acc_is_one && acc_reg != nm1) begin
                        res_next   = mrwt_pkg::V_COMPOSITE;
                        state_next = mrwt_pkg::ST_FINISH;
                    end else if (t_reg == mrwt_pkg::T_W'(1)) begin
                        res_next   = sq_is_one ? mrwt_pkg::V_PROBABLE
                                               : mrwt_pkg::V_COMPOSITE;
                        state_next = mrwt_pkg::ST_FINISH;
                    end
                end
            end
            mrwt_pkg::ST_FINISH: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = mrwt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrwt_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.start |-> !mrsp.busy)
        else $error("multiply started while busy");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != mrwt_pkg::ST_IDLE)
        else $error("accepted item not taken up");
    a_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mrwt_pkg::ST_SPLIT |-> n_reg[0] && n_reg != mrwt_pkg::NUM_BITS'(1))
        else $error("trivial candidate reached the witness loop");
`endif

endmodule

/* hw/rtl/mrwt_modmul.sv */
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on mrwt_pkg.
module mrwt_modmul (
    input  logic               aclk,
    input  logic               aresetn,
    input  mrwt_pkg::mul_req_t req,
    output mrwt_pkg::mul_rsp_t rsp
);

    mrwt_pkg::word_t acc_reg, acc_next;
    mrwt_pkg::word_t x_reg, m_reg, y_reg;
    logic [mrwt_pkg::CNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg;

    logic [mrwt_pkg::NUM_BITS:0] dbl_s, add_s;
    mrwt_pkg::word_t dbl;

    // acc = 2*acc mod m, then + x mod m when the multiplier bit is set
    always_comb begin
        dbl_s = {acc_reg, 1'b0};
        if (dbl_s >= {1'b0, m_reg}) begin
            dbl_s = dbl_s - {1'b0, m_reg};
        end
        dbl   = dbl_s[mrwt_pkg::NUM_BITS-1:0];
        add_s = {1'b0, dbl} + {1'b0, x_reg};
        if (add_s >= {1'b0, m_reg}) begin
            add_s = add_s - {1'b0, m_reg};
        end
        acc_next = y_reg[mrwt_pkg::NUM_BITS-1] ? add_s[mrwt_pkg::NUM_BITS-1:0] : dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                x_reg    <= req.x;
                y_reg    <= req.y;
                m_reg    <= req.m;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                y_reg   <= {y_reg[mrwt_pkg::NUM_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mrwt_pkg::CNT_W'(mrwt_pkg::NUM_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

/* verif/mrwt_checker.sv */
`timescale 1ns / 100ps
// Checker for the Miller-Rabin witness test block: predicts each verdict and
// compares it with the result channel. Depends on mrwt_pkg.
module mrwt_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] candidate, [127:64] base
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,   // [1:0] verdict, [7:2] zero
    output int           fail_cnt,
    output int           pending_cnt,
    output int           verdict_cnt
);

    mrwt_pkg::verdict_t verdict_q[$];

    function automatic mrwt_pkg::word_t mul_mod(mrwt_pkg::word_t x, mrwt_pkg::word_t y,
                                                mrwt_pkg::word_t m);
        logic [2*mrwt_pkg::NUM_BITS-1:0] p;
        p = x * y;
        p = p % m;
        return p[mrwt_pkg::NUM_BITS-1:0];
    endfunction

    function automatic mrwt_pkg::word_t pow_mod(mrwt_pkg::word_t b, mrwt_pkg::word_t e,
                                                mrwt_pkg::word_t m);
        mrwt_pkg::word_t acc;
        acc = 1;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic mrwt_pkg::verdict_t predict_verdict(mrwt_pkg::word_t n,
                                                           mrwt_pkg::word_t a);
        mrwt_pkg::word_t u, cur, sq;
        int t;
        if (n == 2) return mrwt_pkg::V_PRIME;
        if (n < 2 || !n[0]) return mrwt_pkg::V_TRIVIAL;
        u = n - 1;
        t = 0;
        sq = 0;
        while (!u[0]) begin
            u = u >> 1;
            t++;
        end
        cur = pow_mod(a % n, u, n);
        for (int i = 0; i < t; i++) begin
            sq = mul_mod(cur, cur, n);
            if (sq == 1 && cur != 1 && cur != n - 1) return mrwt_pkg::V_COMPOSITE;
            cur = sq;
        end
        return (sq != 1) ? mrwt_pkg::V_COMPOSITE : mrwt_pkg::V_PROBABLE;
    endfunction

    assign pending_cnt = verdict_q.size();

    always @(posedge aclk) begin
        mrwt_pkg::verdict_t want;
        if (!aresetn) begin
            fail_cnt    <= 0;
            verdict_cnt <= 0;
        end else begin
            if (s_tvalid && s_tready)
                verdict_q.push_back(predict_verdict(s_tdata[mrwt_pkg::NUM_BITS-1:0],
                                                    s_tdata[64 +: mrwt_pkg::NUM_BITS]));
            if (m_tvalid && m_tready) begin
                verdict_cnt <= verdict_cnt + 1;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict transfer, expected none, got %0d",
                             $time, m_tdata);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata !== {6'd0, want}) begin
                        $display("%0t: verdict mismatch, expected %0d, got %0d",
                                 $time, want, m_tdata);
                        fail_cnt <= fail_cnt + 1;
                    end
                end
            end
        end
    end

endmodule

/* verif/tb_miller_rabin_witness_test.sv */
`timescale 1ns / 100ps
// Testbench top for miller_rabin_witness_test: stimulus, handshake pacing and
// verdict. Depends on mrwt_pkg, the block and mrwt_checker.
module tb_miller_rabin_witness_test;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // [63:0] candidate, [127:64] base
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;   // [1:0] verdict, [7:2] zero

    int fail_cnt, pending_cnt, verdict_cnt;
    int sent_cnt;
    int idle_pct;    // chance that the sender pauses after a transfer
    int stall_pct;   // chance that the receiver holds tready low

    // a few known primes of assorted widths
    logic [63:0] prime_tab [8] = '{64'd3, 64'd7919, 64'd65537, 64'd2147483647,
                                   64'd4294967291, 64'd1000000007,
                                   64'd18446744073709551557, 64'd2305843009213693951};

    miller_rabin_witness_test u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mrwt_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt),
        .verdict_cnt (verdict_cnt)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // hard stop, far beyond the worst case of a 64-bit item
    initial begin
        #(64'd1_000_000_000);
        $display("FAIL");
        $finish;
    end

    // one transfer in; tready is read mid-cycle where it is stable
    task automatic send_item(input logic [63:0] cand, input logic [63:0] wit);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {wit, cand};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        sent_cnt++;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // base from 2 to n-2 for most candidates above 4, raw 64-bit noise otherwise
    function automatic logic [63:0] pick_base(logic [63:0] cand);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if (cand > 4 && $urandom_range(9) != 0)
            return 64'd2 + raw % (cand - 64'd3);
        return raw;
    endfunction

    task automatic send_random;
        logic [63:0] cand;
        case ($urandom_range(9))
            0, 1, 2: cand = {48'd0, 16'($urandom)} | 64'd1;           // short, quick
            3, 4:    cand = {32'd0, $urandom} | 64'd1;
            5:       cand = {$urandom, $urandom} | 64'd1;             // full width odd
            6:       cand = {$urandom, $urandom};                     // any parity
            7:       cand = prime_tab[$urandom_range(7)];
            8:       cand = 64'($urandom_range(3, 40000) | 1) *
                            64'($urandom_range(3, 40000) | 1);          // composite
            default: cand = 64'($urandom_range(0, 20));
        endcase
        send_item(cand, pick_base(cand));
    endtask

    task automatic drain;
        do @(posedge aclk); while (pending_cnt != 0);
    endtask

    initial begin
        int per_phase [4] = '{120, 150, 150, 140};
        int idle_tab  [4] = '{0, 76, 0, 35};
        int stall_tab [4] = '{0, 0, 76, 35};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        idle_pct  = 0;
        stall_pct = 0;
        sent_cnt  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: trivial candidates, extremes, base reduction corners
        send_item(64'd0, 64'd0);
        send_item(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'd2, 64'd5);
        send_item(64'd4, 64'd3);
        send_item(64'hFFFF_FFFF_FFFF_FFFE, 64'd3);        // large even
        send_item(64'd3, 64'd2);
        send_item(64'd561, 64'd2);                        // Carmichael, nontrivial root
        send_item(64'd561, 64'd50);
        send_item(64'd91, 64'd3);                         // nontrivial root of one
        send_item(64'd97, 64'd0);                         // base reduces to zero
        send_item(64'd97, 64'd97);                        // base equal to n
        send_item(64'd97, 64'd98);                        // base reduces to one
        send_item(64'd97, 64'd96);                        // base is n-1
        send_item(64'd97, 64'hFFFF_FFFF_FFFF_FFFF);       // base above range
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'd2);        // all ones, composite
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(64'd18446744073709551557, 64'd2);       // largest 64-bit prime
        send_item(64'd18446744073709551557, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'd3215031751, 64'd2);                 // strong pseudoprime base 2
        send_item(64'd3215031751, 64'd11);
        s_tvalid <= 1'b0;
        drain();  // sender holds off until every verdict is in

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            for (int i = 0; i < per_phase[ph]; i++) send_random();
            if (ph == 1) begin
                s_tvalid <= 1'b0;
                drain();
            end
        end
        s_tvalid <= 1'b0;
        stall_pct = 0;

        drain();
        repeat (9000) @(posedge aclk);

        $display("Sent %0d candidate/base pairs, %0d verdicts checked, over four pacing phases",
                 sent_cnt, verdict_cnt);
        $display("including trivial, even, prime, Carmichael and out-of-range base cases.");
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
